[sv/umg_pkg.sv]
package umg_pkg;

    // geometry
    localparam int MAX_COLUMNS = 512;
    localparam int KERNEL_SIZE = 5;
    localparam int HIST_AW     = $clog2(4 * MAX_COLUMNS + 8);
    localparam int HIST_DEPTH  = 2 ** HIST_AW;
    localparam int FILL_MAX    = 4 * MAX_COLUMNS + 5;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int W_W         = $clog2(MAX_COLUMNS + 1);

    // arithmetic widths
    localparam int PIX_W  = 8;
    localparam int COEF_W = 16;
    localparam int PROD_W = PIX_W + COEF_W;
    localparam int ROW_W  = PROD_W + 3;
    localparam int SUM_W  = PROD_W + 5;
    localparam int NUM_W  = SUM_W + 6;
    localparam int N_COEF = 6;

    // register reset values
    localparam logic [9:0] WIDTH_RESET = 10'd352;
    localparam logic [3:0] GAIN_RESET  = 4'd3;

    typedef logic [HIST_AW-1:0] hist_addr_t;
    typedef logic [N_COEF-1:0][COEF_W-1:0] coef_arr_t;

    localparam coef_arr_t COEF_RESET = {16'd77, 16'd537, 16'd1023,
                                        16'd3723, 16'd7101, 16'd13543};

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH = 3'd0,
        CFG_GAIN        = 3'd1,
        CFG_COEF_CENTER = 3'd2,
        CFG_EDGE_ONE    = 3'd3,
        CFG_DIAG_ONE    = 3'd4,
        CFG_EDGE_TWO    = 3'd5,
        CFG_KNIGHT      = 3'd6,
        CFG_CORNER      = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        RL_IDLE,
        RL_TAP1,
        RL_TAP2,
        RL_TAP3,
        RL_TAP4,
        RL_PRIME
    } reload_t;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_first;
    } out_word_t;

    typedef struct packed {
        logic             is_real;
        logic [PIX_W-1:0] pix;
    } sample_t;

    typedef struct packed {
        logic                   accept;
        logic                   advance;
        hist_addr_t             wr_addr;
        hist_addr_t             base_addr;
        logic                   load_en;
        logic [1:0]             load_idx;
        hist_addr_t             fill;
        logic [KERNEL_SIZE-1:0] col_ok;
        sample_t                live;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] center;
        logic             first;
    } meta_t;

    // weight slot from absolute row and column offsets
    function automatic logic [2:0] coef_index(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] lo;
        logic [1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (hi == 2'd0)      return 3'd0;
        else if (hi == 2'd1) return (lo == 2'd0) ? 3'd1 : 3'd2;
        else if (lo == 2'd0) return 3'd3;
        else if (lo == 2'd1) return 3'd4;
        else                 return 3'd5;
    endfunction

endpackage

[sv/umg_cell.sv]
module umg_cell (
    input  logic                        clk,
    input  logic [2:0]                  row,
    input  umg_pkg::hist_addr_t         row_offset,
    input  umg_pkg::cell_ctrl_t         ctrl,
    input  umg_pkg::coef_arr_t          coef,
    input  logic [umg_pkg::SUM_W-1:0]   psum_in,
    output logic [umg_pkg::SUM_W-1:0]   psum_out,
    output umg_pkg::sample_t            mid
);
    import umg_pkg::*;

    sample_t          mem [HIST_DEPTH];
    sample_t          rd_reg;
    sample_t          tap_reg [4];
    logic [PIX_W-1:0] win_reg [KERNEL_SIZE];
    logic [PROD_W-1:0] prod_reg [KERNEL_SIZE];
    logic [ROW_W-1:0] row_sum_reg;

    sample_t          tapv [KERNEL_SIZE];
    logic [PIX_W-1:0] masked [KERNEL_SIZE];
    logic             ok [KERNEL_SIZE];
    logic [1:0]       row_abs;

    assign row_abs = (row >= 3'd2) ? 2'(row - 3'd2) : 2'(3'd2 - row);

    // history copy for this row, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            mem[ctrl.wr_addr] <= ctrl.live;
        end
        rd_reg <= mem[ctrl.base_addr - row_offset];
    end

    // taps: newest from memory (live word on the top row)
    always_comb
    begin
        tapv[0] = (row == 3'd0) ? ctrl.live : rd_reg;
        for (int j = 1; j < KERNEL_SIZE; j++)
        begin
            tapv[j] = tap_reg[j-1];
        end
        for (int j = 0; j < KERNEL_SIZE; j++)
        begin
            ok[j]     = ctrl.col_ok[j] && ((row_offset + HIST_AW'(j)) < ctrl.fill);
            masked[j] = ok[j] ? tapv[j].pix : '0;
        end
        mid.is_real = ok[2] && tapv[2].is_real;
        mid.pix     = masked[2];
    end

    // tap shift on each word, reload after a width change
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            tap_reg[0] <= tapv[0];
            for (int j = 1; j < 4; j++)
            begin
                tap_reg[j] <= tap_reg[j-1];
            end
        end
        else if (ctrl.load_en)
        begin
            tap_reg[ctrl.load_idx] <= rd_reg;
        end
    end

    // window row, products, row sum
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int j = 0; j < KERNEL_SIZE; j++)
            begin
                win_reg[j]  <= masked[j];
                prod_reg[j] <= PROD_W'(win_reg[j]) * PROD_W'(coef[coef_index(row_abs,
                               (j >= 2) ? 2'(j - 2) : 2'(2 - j))]);
            end
            row_sum_reg <= ROW_W'(prod_reg[0]) + ROW_W'(prod_reg[1]) + ROW_W'(prod_reg[2])
                         + ROW_W'(prod_reg[3]) + ROW_W'(prod_reg[4]);
        end
    end

    // partial sum handed down the chain
    assign psum_out = psum_in + SUM_W'(row_sum_reg);

endmodule

[sv/unsharp_mask_gauss5x5.sv]
// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready  | in_data   (req_type, pixel_in, frame_start)
// out     | output    | out_valid / out_ready| out_data  (pixel_out, row_first)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word is taken per cycle; a result passes the window, product, row-sum, total
// and output registers after the word that completes its window, 2*width+2 words
// after its own pixel. a write of image_width starts a tap reload from the five row
// stores, during which no word is taken. other writes cost nothing.
// reset clears control state only; line stores are masked by a fill count.
// the whole pipeline holds while a result waits at the output.
module unsharp_mask_gauss5x5 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  umg_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output umg_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import umg_pkg::*;

    logic [9:0]  cfg_width_reg;
    logic [3:0]  gain_reg;
    coef_arr_t   coef_reg;

    reload_t     rl_reg, rl_next;
    logic [2:0]  rl_back;
    logic        rl_load;
    logic [1:0]  rl_idx;

    hist_addr_t  wr_reg, wr_next;
    hist_addr_t  fill_reg, fill_eff;
    logic [COL_W-1:0] col_reg;
    logic [W_W-1:0]   w_eff, c_base, c_cur, c_inc, cc;
    logic [KERNEL_SIZE-1:0] col_ok;
    hist_addr_t  row_off [KERNEL_SIZE];

    logic        advance, accept, clear, width_wr;
    cell_ctrl_t  ctrl;
    logic [SUM_W-1:0] psum [KERNEL_SIZE+1];
    sample_t     mid [KERNEL_SIZE];

    meta_t       meta0_reg, meta1_reg, meta2_reg, meta3_reg;
    logic [SUM_W-1:0] total_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;

    logic [NUM_W-1:0] scaled, sub;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0] q;
    logic [PIX_W-1:0] res;

    // handshakes
    assign cfg_ready = 1'b1;
    assign width_wr  = cfg_valid && (cfg_index == CFG_IMAGE_WIDTH);
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = (rl_reg == RL_IDLE) && advance;
    assign accept    = in_valid && in_ready;
    assign clear     = accept && !in_data.req_type && in_data.frame_start;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg <= WIDTH_RESET;
            gain_reg      <= GAIN_RESET;
            coef_reg      <= COEF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: cfg_width_reg <= cfg_data[9:0];
                CFG_GAIN:        gain_reg <= cfg_data[3:0];
                default:         coef_reg[cfg_index - CFG_COEF_CENTER] <= cfg_data;
            endcase
        end
    end

    // effective width
    always_comb
    begin
        if (int'(cfg_width_reg) < KERNEL_SIZE)      w_eff = W_W'(KERNEL_SIZE);
        else if (int'(cfg_width_reg) > MAX_COLUMNS) w_eff = W_W'(MAX_COLUMNS);
        else                                        w_eff = W_W'(cfg_width_reg);
    end

    // tap reload sequencer: next state
    always_comb
    begin
        if (width_wr)
        begin
            rl_next = RL_TAP1;
        end
        else
        begin
            unique case (rl_reg)
                RL_IDLE:  rl_next = RL_IDLE;
                RL_TAP1:  rl_next = RL_TAP2;
                RL_TAP2:  rl_next = RL_TAP3;
                RL_TAP3:  rl_next = RL_TAP4;
                RL_TAP4:  rl_next = RL_PRIME;
                RL_PRIME: rl_next = RL_IDLE;
                default:  rl_next = RL_IDLE;
            endcase
        end
    end

    // tap reload sequencer: outputs
    always_comb
    begin
        rl_back = 3'd0;
        rl_load = 1'b0;
        rl_idx  = 2'd0;
        unique case (rl_reg)
            RL_IDLE:  ;
            RL_TAP1:  rl_back = 3'd1;
            RL_TAP2:  begin rl_back = 3'd2; rl_load = 1'b1; rl_idx = 2'd0; end
            RL_TAP3:  begin rl_back = 3'd3; rl_load = 1'b1; rl_idx = 2'd1; end
            RL_TAP4:  begin rl_back = 3'd4; rl_load = 1'b1; rl_idx = 2'd2; end
            RL_PRIME: begin rl_back = 3'd0; rl_load = 1'b1; rl_idx = 2'd3; end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rl_reg <= RL_IDLE;
        else        rl_reg <= rl_next;
    end

    // column and fill tracking
    always_comb
    begin
        int colv;
        wr_next  = wr_reg + HIST_AW'(accept);
        fill_eff = (clear ? '0 : fill_reg) + HIST_AW'(1);
        c_base   = clear ? '0 : W_W'(col_reg);
        c_cur    = (c_base >= w_eff) ? '0 : c_base;
        c_inc    = c_cur + W_W'(1);
        cc       = (c_cur >= W_W'(2)) ? c_cur - W_W'(2) : c_cur + w_eff - W_W'(2);
        for (int j = 0; j < KERNEL_SIZE; j++)
        begin
            colv      = int'(cc) + 2 - j;
            col_ok[j] = (colv >= 0) && (colv < int'(w_eff));
            row_off[j] = HIST_AW'(j * int'(w_eff));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            fill_reg <= '0;
            col_reg  <= '0;
        end
        else if (accept)
        begin
            wr_reg   <= wr_next;
            fill_reg <= (int'(fill_eff) > FILL_MAX) ? HIST_AW'(FILL_MAX) : fill_eff;
            col_reg  <= (c_inc >= w_eff) ? '0 : COL_W'(c_inc);
        end
    end

    // cell control bundle
    always_comb
    begin
        ctrl.accept       = accept;
        ctrl.advance      = advance;
        ctrl.wr_addr      = wr_reg;
        ctrl.base_addr    = (rl_reg == RL_IDLE) ? wr_next : wr_reg - HIST_AW'(rl_back);
        ctrl.load_en      = rl_load;
        ctrl.load_idx     = rl_idx;
        ctrl.fill         = fill_eff;
        ctrl.col_ok       = col_ok;
        ctrl.live.is_real = !in_data.req_type;
        ctrl.live.pix     = in_data.req_type ? '0 : in_data.pixel_in;
    end

    // row cells, partial sum passed from row to row
    assign psum[0] = '0;
    for (genvar r = 0; r < KERNEL_SIZE; r++)
    begin : g_row
        umg_cell u_cell (
            .clk        (clk),
            .row        (3'(r)),
            .row_offset (row_off[r]),
            .ctrl       (ctrl),
            .coef       (coef_reg),
            .psum_in    (psum[r]),
            .psum_out   (psum[r+1]),
            .mid        (mid[r])
        );
    end

    // pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta0_reg <= '0;
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
        end
        else if (advance)
        begin
            meta0_reg.valid  <= accept && mid[2].is_real;
            meta0_reg.center <= mid[2].pix;
            meta0_reg.first  <= (cc == '0);
            meta1_reg        <= meta0_reg;
            meta2_reg        <= meta1_reg;
            meta3_reg        <= meta2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            total_reg <= psum[KERNEL_SIZE];
        end
    end

    // sharpen and clamp
    always_comb
    begin
        scaled = (NUM_W'(meta3_reg.center) * NUM_W'({1'b0, gain_reg} + 5'd1)) << 16;
        sub    = NUM_W'(gain_reg) * NUM_W'(total_reg);
        num    = $signed(scaled) - $signed(sub);
        q      = NUM_W'(num >>> 16);
        if (num < 0)                res = '0;
        else if (q > NUM_W'(255))   res = 8'd255;
        else                        res = q[PIX_W-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)       out_valid_reg <= 1'b0;
        else if (advance) out_valid_reg <= meta3_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.pixel_out <= res;
            out_data_reg.row_first <= meta3_reg.first;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("word taken while output stalled");

    a_width_reload: assert property (@(posedge clk) disable iff (!rst_n)
        width_wr |=> !in_ready)
        else $error("word taken during tap reload");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= FILL_MAX)
        else $error("fill count overrun");

endmodule

[dv/umg_checker.sv]
module umg_checker
    import umg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_word_t   in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_word_t  out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  cfg_idx_t   cfg_index,
    input  logic [15:0] cfg_data,
    output int         fails,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DELAY_LEN = 4 * MAX_COLUMNS + 8;

    // shadow of the block's registers
    logic [9:0]  width_reg;
    logic [3:0]  gain_reg;
    logic [15:0] weights [N_COEF];

    // delay line of past samples and their real marks
    logic [7:0]  delay_pix  [DELAY_LEN];
    bit          delay_real [DELAY_LEN];
    int unsigned wr_ptr;
    int unsigned column;

    out_word_t sharpened_q [$];

    function automatic int unsigned tap(int unsigned back_cnt);
        return (wr_ptr + DELAY_LEN - (back_cnt % DELAY_LEN)) % DELAY_LEN;
    endfunction

    // kernel weight from absolute row and column offsets
    function automatic logic [15:0] kernel_weight(int unsigned dy, int unsigned dx);
        int unsigned near_ax;
        int unsigned far_ax;
        near_ax = (dy < dx) ? dy : dx;
        far_ax  = (dy < dx) ? dx : dy;
        case (far_ax)
            0: return weights[0];
            1: return (near_ax == 0) ? weights[1] : weights[2];
            default:
                case (near_ax)
                    0: return weights[3];
                    1: return weights[4];
                    default: return weights[5];
                endcase
        endcase
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < DELAY_LEN; i++)
        begin
            delay_pix[i]  = '0;
            delay_real[i] = 1'b0;
        end
        wr_ptr = 0;
        column = 0;
    endfunction

    // one accepted input word: update history, maybe queue a sharpened pixel
    function automatic void sharpen_step(in_word_t w_in);
        int unsigned w;
        int unsigned c;
        int unsigned cc;
        int unsigned k0;
        longint unsigned blur_sum;
        longint signed num;
        longint unsigned q;
        int col_i;
        out_word_t res;
        w = width_reg;
        if (w < KERNEL_SIZE) w = KERNEL_SIZE;
        if (w > MAX_COLUMNS) w = MAX_COLUMNS;
        if (!w_in.req_type && w_in.frame_start) clear_history();
        if (column >= w) column = 0;
        delay_pix[wr_ptr]  = w_in.req_type ? 8'd0 : w_in.pixel_in;
        delay_real[wr_ptr] = !w_in.req_type;
        c  = column;
        cc = (c >= 2) ? c - 2 : c + w - 2;
        k0 = 2 * w + 2;
        if (delay_real[tap(k0)])
        begin
            blur_sum = 0;
            for (int dr = -2; dr <= 2; dr++)
                for (int dc = -2; dc <= 2; dc++)
                begin
                    col_i = int'(cc) + dc;
                    if (col_i >= 0 && col_i < int'(w))
                        blur_sum += longint'(delay_pix[tap(int'(k0) - dr * int'(w) - dc)])
                                  * kernel_weight(dr < 0 ? -dr : dr, dc < 0 ? -dc : dc);
                end
            num = longint'(delay_pix[tap(k0)]) * 65536 * (1 + longint'(gain_reg))
                - longint'(gain_reg) * longint'(blur_sum);
            if (num < 0)
                res.pixel_out = 8'd0;
            else
            begin
                q = num >>> 16;
                res.pixel_out = (q > 255) ? 8'd255 : q[7:0];
            end
            res.row_first = (cc == 0);
            sharpened_q.push_back(res);
        end
        wr_ptr = (wr_ptr + 1) % DELAY_LEN;
        column = c + 1;
        if (column >= w) column = 0;
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            width_reg = WIDTH_RESET;
            gain_reg  = GAIN_RESET;
            for (int i = 0; i < N_COEF; i++) weights[i] = COEF_RESET[i];
            clear_history();
            sharpened_q.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            // result side first
            if (out_valid && out_ready)
            begin
                if (sharpened_q.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h/%b",
                             $time, out_data.pixel_out, out_data.row_first);
                    fails++;
                end
                else
                begin
                    exp_w = sharpened_q.pop_front();
                    if (exp_w.pixel_out !== out_data.pixel_out)
                    begin
                        $display("%0t: pixel_out mismatch: expected %h, actual %h",
                                 $time, exp_w.pixel_out, out_data.pixel_out);
                        fails++;
                    end
                    if (exp_w.row_first !== out_data.row_first)
                    begin
                        $display("%0t: row_first mismatch: expected %b, actual %b",
                                 $time, exp_w.row_first, out_data.row_first);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH: width_reg = cfg_data[9:0];
                    CFG_GAIN:        gain_reg  = cfg_data[3:0];
                    default:         weights[int'(cfg_index) - int'(CFG_COEF_CENTER)] = cfg_data;
                endcase
            end
            if (in_valid && in_ready)
                sharpen_step(in_data);
            pending = sharpened_q.size();
        end
    end

endmodule

[dv/testbench.sv]
module testbench;
    import umg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 40000;
    localparam int ITEM_TARGET = 560;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_idx_t   cfg_index;
    logic [15:0] cfg_data;
    int         fails;
    int         pending;
    int         idle_cycles;
    int         burst_left;
    int         items_sent;
    int         cur_width;

    unsharp_mask_gauss5x5 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    umg_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern; a new random mode is drawn each time the mode counter runs out
    always @(posedge clk)
    begin
        static int stall_mode = 0;
        static int mode_cnt = 0;
        if (mode_cnt == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_cnt = 64;
        end
        mode_cnt--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready)
                 || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            cur_width = (val[9:0] < 5) ? 5 : (val[9:0] > MAX_COLUMNS) ? MAX_COLUMNS
                                                                       : int'(val[9:0]);
    endtask

    // one word with bursty sender gaps
    task automatic send_word(logic pad, logic [7:0] pix, logic fs);
        in_word_t w;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        w.req_type    = pad;
        w.pixel_in    = pix;
        w.frame_start = fs;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic flush_rows();
        repeat (2 * cur_width + 2)
            send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // idle point before register writes
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] coef_v;
        int rows;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        burst_left = 0;
        items_sent = 0;
        cur_width = int'(WIDTH_RESET);
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: width below range, max gain, extreme weights
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_GAIN, 16'd15);
        write_reg(CFG_COEF_CENTER, 16'd0);
        write_reg(CFG_EDGE_ONE, 16'hFFFF);
        write_reg(CFG_DIAG_ONE, 16'd0);
        write_reg(CFG_EDGE_TWO, 16'hFFFF);
        write_reg(CFG_KNIGHT, 16'h5555);
        write_reg(CFG_CORNER, 16'hAAAA);
        // checkerboard drives both clamps; pads and a padded frame start inside
        send_word(1'b0, 8'd255, 1'b1);
        for (int i = 1; i < 12; i++)
            send_word(1'b0, (i % 2) ? 8'd0 : 8'd255, 1'b0);
        send_word(1'b1, 8'd255, 1'b1);
        send_word(1'b1, 8'd0, 1'b0);
        for (int i = 0; i < 4; i++) send_word(1'b0, 8'd255, 1'b0);
        // new frame drops what is pending
        send_word(1'b0, 8'd128, 1'b1);
        for (int i = 0; i < 6; i++) send_word(1'b0, 8'h55 << (i % 2), 1'b0);
        flush_rows();
        drain();

        // width above range, a few real pixels left in the line stores
        write_reg(CFG_IMAGE_WIDTH, 16'd1023);
        write_reg(CFG_GAIN, 16'd0);
        send_word(1'b0, 8'd200, 1'b1);
        for (int i = 0; i < 7; i++) send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);

        // random phases; pauses until all results are in between them
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(0, 4)));
            else if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(13, 40)));
            else
                write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(5, 12)));
            write_reg(CFG_GAIN, 16'($urandom_range(0, 15)));
            for (int k = 0; k < N_COEF; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       coef_v = 16'd0;
                    1:       coef_v = 16'hFFFF;
                    default: coef_v = 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 6));
                endcase
                if ($urandom_range(0, 1))
                    write_reg(cfg_idx_t'(int'(CFG_COEF_CENTER) + k), coef_v);
            end
            // a frame of random rows, with some noise and broken frames
            rows = $urandom_range(1, 6);
            if ($urandom_range(0, 4) != 0)
                send_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            for (int i = 0; i < rows * cur_width; i++)
            begin
                case ($urandom_range(0, 39))
                    0:       send_word(1'b1, 8'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1)));
                    1:       send_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                    default: send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                endcase
            end
            // sometimes leave the frame open so a width change lands mid-row
            if ($urandom_range(0, 3) != 0)
                flush_rows();
        end
        if (cur_width > 0)
            flush_rows();

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[files.f]
sv/umg_pkg.sv
sv/umg_cell.sv
sv/unsharp_mask_gauss5x5.sv
dv/umg_checker.sv
dv/testbench.sv
